// ===== hdl/smt_pkg.sv =====
// ----------------------------------------------------------------------------
// smt_pkg: shared types and codes of the sorted multiset table
// Item and result layouts, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int KEY_IN_W      = 32;
  localparam int CNT_W         = 7;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KEY_IN_W-1:0] key;
    logic [CNT_W-1:0]    copies;
  } smt_in_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] erased;
    logic [CNT_W-1:0] fill;
  } smt_out_t;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;   // open a slot at the insert point and write the key
    logic del;   // close the slot at the insert point
  } cell_ctl_t;

endpackage

// ===== hdl/smt_cell.sv =====
// ----------------------------------------------------------------------------
// smt_cell: one slot of the sorted table
// Holds one key and its valid bit, compares it with the item key, and
// moves data to or from its neighbors when the row shifts.
// ----------------------------------------------------------------------------
module smt_cell #(
  parameter int KEY_WIDTH = smt_pkg::KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  smt_pkg::cell_ctl_t   ctl,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 ge_left,
  input  logic                 ge_self,
  input  logic [KEY_WIDTH-1:0] left_data,
  input  logic                 left_valid,
  input  logic [KEY_WIDTH-1:0] right_data,
  input  logic                 right_valid,
  output logic [KEY_WIDTH-1:0] data,
  output logic                 valid,
  output logic                 lt,
  output logic                 eq
);

  assign lt = valid && (data < key);
  assign eq = valid && (data == key);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ge_left) begin
        data <= left_data;
      end else if (ge_self) begin
        data <= key;
      end
    end else if (ctl.del && ge_self) begin
      data <= right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      if (ge_left) begin
        valid <= left_valid;
      end else if (ge_self) begin
        valid <= 1'b1;
      end
    end else if (ctl.del && ge_self) begin
      valid <= right_valid;
    end
  end

endmodule

// ===== hdl/sorted_multiset_table.sv =====
// ----------------------------------------------------------------------------
// sorted_multiset_table: ordered key table with find, insert and erase
// Row of compare-and-shift cells under a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every cell compares
// its key with the item key in the cycle after acceptance, which locates the
// lower bound. A find then completes: its result strobes on done in the cycle
// after, in the same cycle in which a new item may be accepted. An insert of
// n copies shifts the row up one slot per cycle; one refused as full or with
// n zero completes straight from the search. An erase that removes m copies
// shifts the row down one slot per cycle; when the key is absent it completes
// straight from the search. done is high for exactly one
// cycle and the result must be captured then; there is no back-pressure.
// ----------------------------------------------------------------------------
module sorted_multiset_table #(
  parameter int DEPTH     = smt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = smt_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  smt_pkg::smt_in_t  item,
  output logic              done,
  output smt_pkg::smt_out_t result
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OW    = smt_pkg::CNT_W;
  localparam int NW    = ((CW > OW) ? CW : OW) + 1;
  localparam int XW    = (KEY_WIDTH > smt_pkg::KEY_IN_W) ? KEY_WIDTH : smt_pkg::KEY_IN_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_INSERT = 4'b0100,
    S_ERASE  = 4'b1000
  } state_t;

  state_t                       state;
  logic [smt_pkg::OP_W-1:0]     op_r;
  logic [KEY_WIDTH-1:0]         key_r;
  logic [OW-1:0]                ins_left;
  logic [CW-1:0]                occ;
  logic [DEPTH-1:0]             ge_r;

  logic [KEY_WIDTH-1:0]         cdata [DEPTH];
  logic [DEPTH-1:0]             cvalid;
  logic [DEPTH-1:0]             clt;
  logic [DEPTH-1:0]             ceq;

  logic [DEPTH-1:0]             ge;
  logic [DEPTH-1:0]             edge_c;
  logic [DEPTH-1:0]             edge_r;
  logic [CW-1:0]                pos_c;
  logic                         found_c;
  logic                         head_eq;
  logic [NW-1:0]                occ_sum;
  logic [XW-1:0]                key_x;
  smt_pkg::cell_ctl_t           ctl;

  assign busy = (state != S_IDLE);

  // keys are sorted, so the "less than" cells form a prefix of the row
  assign ge      = ~clt;
  assign edge_c  = ge & ~{ge[DEPTH-2:0], 1'b0};
  assign edge_r  = ge_r & ~{ge_r[DEPTH-2:0], 1'b0};
  assign found_c = |(edge_c & ceq);
  assign head_eq = |(edge_r & ceq);
  assign occ_sum = NW'(occ) + NW'(ins_left);
  assign key_x   = XW'(item.key);

  always_comb begin
    pos_c = (~|edge_c) ? CW'(DEPTH) : '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (edge_c[i]) begin
        pos_c = pos_c | CW'(i);
      end
    end
  end

  always_comb begin
    ctl.ins = (state == S_INSERT);
    ctl.del = (state == S_ERASE) && head_eq;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] ldata;
    logic [KEY_WIDTH-1:0] rdata;
    logic                 lvalid;
    logic                 rvalid;
    logic                 gel;

    if (i == 0) begin : g_first
      assign ldata  = '0;
      assign lvalid = 1'b0;
      assign gel    = 1'b0;
    end else begin : g_inner_l
      assign ldata  = cdata[i-1];
      assign lvalid = cvalid[i-1];
      assign gel    = ge_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rdata  = '0;
      assign rvalid = 1'b0;
    end else begin : g_inner_r
      assign rdata  = cdata[i+1];
      assign rvalid = cvalid[i+1];
    end

    smt_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key_r),
      .ge_left     (gel),
      .ge_self     (ge_r[i]),
      .left_data   (ldata),
      .left_valid  (lvalid),
      .right_data  (rdata),
      .right_valid (rvalid),
      .data        (cdata[i]),
      .valid       (cvalid[i]),
      .lt          (clt[i]),
      .eq          (ceq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      occ   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= item.opcode;
            key_r    <= KEY_WIDTH'(key_x);
            ins_left <= item.copies;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          ge_r            <= ge;
          result.position <= OW'(pos_c);
          result.erased   <= '0;
          result.fill     <= OW'(occ);
          case (op_r)
            smt_pkg::OP_INSERT: begin
              if (occ_sum > NW'(DEPTH)) begin
                result.status <= smt_pkg::ST_FULL;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else if (ins_left == '0) begin
                result.status <= smt_pkg::ST_OK;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else begin
                state <= S_INSERT;
              end
            end
            smt_pkg::OP_ERASE: begin
              if (found_c) begin
                state <= S_ERASE;
              end else begin
                result.status <= smt_pkg::ST_MISS;
                done          <= 1'b1;
                state         <= S_IDLE;
              end
            end
            default: begin
              result.status <= found_c ? smt_pkg::ST_OK : smt_pkg::ST_MISS;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end
        S_INSERT: begin
          // one copy enters at the insert point per cycle
          occ      <= occ + CW'(1);
          ins_left <= ins_left - OW'(1);
          if (ins_left == OW'(1)) begin
            result.status <= smt_pkg::ST_OK;
            result.fill   <= OW'(occ + CW'(1));
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_ERASE: begin
          // keep closing the slot while it still holds the key
          if (head_eq) begin
            occ           <= occ - CW'(1);
            result.erased <= result.erased + OW'(1);
          end else begin
            result.status <= smt_pkg::ST_OK;
            result.fill   <= OW'(occ);
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/smt_checker.sv =====
// ----------------------------------------------------------------------------
// smt_checker: result predictor and scoreboard for the sorted multiset table
// Watches the item and result channels, keeps its own ordered copy of the
// table, works out the result of every accepted item and compares each
// strobed result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module smt_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  smt_pkg::smt_in_t  item,
  input  logic              done,
  input  smt_pkg::smt_out_t result,
  output int                fails,
  output int                pending,
  output int                checked,
  output int                refusals,
  output int                peak_fill
);

  localparam int DEPTH = smt_pkg::DEPTH_DEF;
  localparam int CNT_W = smt_pkg::CNT_W;

  logic [smt_pkg::KEY_IN_W-1:0] held_keys [DEPTH];
  int                           held;
  smt_pkg::smt_out_t            expected_results [$];
  smt_pkg::smt_out_t            oldest;
  int                           fail_count;
  int                           checked_count;
  int                           refused_count;
  int                           fill_high;

  // updates the model table and returns what the block should report
  function automatic smt_pkg::smt_out_t apply_table_op(smt_pkg::smt_in_t it);
    smt_pkg::smt_out_t r;
    int                lb;
    int                run;
    logic              hit;
    r  = '0;
    lb = 0;
    while (lb < held && held_keys[lb] < it.key) lb++;
    hit        = (lb < held) && (held_keys[lb] == it.key);
    r.position = lb[CNT_W-1:0];
    r.status   = smt_pkg::ST_OK;
    case (it.opcode)
      smt_pkg::OP_INSERT: begin
        if (held + int'(it.copies) > DEPTH) begin
          r.status = smt_pkg::ST_FULL;
          refused_count++;
        end else begin
          for (int i = held - 1; i >= lb; i--) held_keys[i + int'(it.copies)] = held_keys[i];
          for (int i = 0; i < int'(it.copies); i++) held_keys[lb + i] = it.key;
          held += int'(it.copies);
        end
      end
      smt_pkg::OP_ERASE: begin
        if (!hit) begin
          r.status = smt_pkg::ST_MISS;
        end else begin
          run = 0;
          while (lb + run < held && held_keys[lb + run] == it.key) run++;
          for (int i = lb; i + run < held; i++) held_keys[i] = held_keys[i + run];
          held    -= run;
          r.erased = run[CNT_W-1:0];
        end
      end
      // find, and the spare code that behaves as find
      default: r.status = hit ? smt_pkg::ST_OK : smt_pkg::ST_MISS;
    endcase
    r.fill = held[CNT_W-1:0];
    if (held > fill_high) fill_high = held;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    held          = 0;
    fail_count    = 0;
    checked_count = 0;
    refused_count = 0;
    fill_high     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      expected_results.delete();
    end else begin
      // a result strobed now belongs to an earlier item, so check before queueing
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %p with no item outstanding", result));
        end else begin
          oldest = expected_results.pop_front();
          checked_count++;
          if (result.status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, oldest.status));
          if (result.position !== oldest.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      result.position, oldest.position));
          if (result.erased !== oldest.erased)
            report_mismatch($sformatf("erased %0d, expected %0d",
                                      result.erased, oldest.erased));
          if (result.fill !== oldest.fill)
            report_mismatch($sformatf("fill %0d, expected %0d",
                                      result.fill, oldest.fill));
        end
      end
      if (start && !busy) expected_results.push_back(apply_table_op(item));
    end
    fails     <= fail_count;
    pending   <= expected_results.size();
    checked   <= checked_count;
    refusals  <= refused_count;
    peak_fill <= fill_high;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top of the sorted multiset table testbench
// Drives directed corner items, then random find, insert and erase traffic
// over a few idle mixes, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;

  localparam int OP_W     = smt_pkg::OP_W;
  localparam int KEY_IN_W = smt_pkg::KEY_IN_W;
  localparam int CNT_W    = smt_pkg::CNT_W;

  localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, acts as find
  localparam int POOL_SIZE   = 8;
  localparam int PHASE_ITEMS = 330;
  localparam int STALL_LIMIT = 2000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              done;
  smt_pkg::smt_in_t  item;
  smt_pkg::smt_out_t result;

  int fails;
  int pending;
  int checked;
  int refusals;
  int peak_fill;
  int sent;
  int quiet_cycles;

  logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
  logic [KEY_IN_W-1:0] stray_keys [$];

  sorted_multiset_table dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  smt_checker chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked),
    .refusals  (refusals),
    .peak_fill (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item or result for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high from one item to the next unless a gap is drawn
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] k,
                           logic [CNT_W-1:0] n, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{opcode: op, key: k, copies: n};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i)
        0:       key_pool[i] = '0;
        1:       key_pool[i] = '1;
        default: key_pool[i] = (i % 2 == 1) ? key_pool[i-1] + 1 : $urandom();
      endcase
    end
  endtask

  task automatic random_item(int idle_pct);
    logic [OP_W-1:0]     op;
    logic [KEY_IN_W-1:0] k;
    logic [CNT_W-1:0]    n;
    int                  pick;
    int                  idx;
    pick = $urandom_range(99);
    if (pick < 35)      op = smt_pkg::OP_INSERT;
    else if (pick < 70) op = smt_pkg::OP_ERASE;
    else if (pick < 95) op = OP_FIND;
    else                op = OP_SPARE;
    pick = $urandom_range(99);
    if (op == smt_pkg::OP_INSERT) begin
      if (pick < 92) begin
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        k = $urandom();
        stray_keys.push_back(k);
      end
    end else if (op == smt_pkg::OP_ERASE && pick < 25 && stray_keys.size() > 0) begin
      idx = $urandom_range(stray_keys.size() - 1);
      k   = stray_keys[idx];
      stray_keys.delete(idx);
    end else begin
      k = (pick < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
    end
    pick = $urandom_range(99);
    if (pick < 80)      n = CNT_W'($urandom_range(1, 3));
    else if (pick < 90) n = CNT_W'($urandom_range(4, 16));
    else if (pick < 94) n = CNT_W'($urandom_range(17, 64));
    else if (pick < 97) n = '0;
    else                n = CNT_W'($urandom_range(65, 127));
    send_item(op, k, n, idle_pct);
  endtask

  // erase every key this phase may have left behind
  task automatic drain_table(int idle_pct);
    for (int i = 0; i < POOL_SIZE; i++)
      send_item(smt_pkg::OP_ERASE, key_pool[i], 7'($urandom()), idle_pct);
    while (stray_keys.size() > 0)
      send_item(smt_pkg::OP_ERASE, stray_keys.pop_front(), 7'($urandom()), idle_pct);
  endtask

  initial begin
    int idle_mix [3];
    idle_mix = '{0, 75, 35};
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    sent  = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners: empty table, duplicates, full refusals, extremes
    send_item(OP_FIND,            32'd0,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd0,          7'd1,   0);
    send_item(smt_pkg::OP_INSERT, 32'd0,          7'd1,   0);
    send_item(smt_pkg::OP_INSERT, 32'hFFFF_FFFF,  7'd1,   0);
    send_item(smt_pkg::OP_INSERT, 32'd5,          7'd3,   0);
    send_item(smt_pkg::OP_INSERT, 32'd5,          7'd0,   0);
    send_item(OP_FIND,            32'd5,          7'd0,   0);
    send_item(OP_FIND,            32'd4,          7'd127, 0);
    send_item(OP_FIND,            32'hFFFF_FFFF,  7'd1,   0);
    send_item(OP_SPARE,           32'd0,          7'd1,   0);
    send_item(smt_pkg::OP_INSERT, 32'd7,          7'd127, 0);
    send_item(smt_pkg::OP_INSERT, 32'd9,          7'd60,  0);
    send_item(smt_pkg::OP_INSERT, 32'd9,          7'd59,  0);
    send_item(smt_pkg::OP_INSERT, 32'd1,          7'd1,   0);
    send_item(OP_FIND,            32'd9,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd9,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd5,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd6,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd0,          7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'hFFFF_FFFF,  7'd1,   0);
    send_item(smt_pkg::OP_INSERT, 32'd3,          7'd64,  0);
    send_item(smt_pkg::OP_INSERT, 32'd2,          7'd0,   0);
    send_item(OP_FIND,            32'd4,          7'd1,   0);
    send_item(OP_SPARE,           32'hAAAA_5555,  7'd1,   0);
    send_item(smt_pkg::OP_ERASE,  32'd3,          7'd1,   0);

    foreach (idle_mix[p]) begin
      refresh_pool();
      repeat (PHASE_ITEMS) random_item(idle_mix[p]);
      drain_table(idle_mix[p]);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("%0d find, insert and erase items sent over three idle mixes, %0d results checked",
             sent, checked);
    $display("table reached %0d entries, %0d inserts refused as full", peak_fill, refusals);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/smt_pkg.sv
hdl/smt_cell.sv
hdl/sorted_multiset_table.sv
tb/smt_checker.sv
tb/tb.sv
